// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/owhfd_pkg.sv -----
// Package with the constants and codes of the single-wire frame decoder.
`timescale 1ns / 1ps

package owhfd_pkg;

	localparam int FRAME_BITS = 40;
	localparam int CNT_W      = 6;
	localparam int PADDR_W    = 3;

	// Operation codes of an input beat.
	localparam logic OP_START   = 1'b0;
	localparam logic OP_CAPTURE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TIMING   = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;

	// Register map (byte addresses).
	localparam logic [PADDR_W-1:0] ADDR_SENSOR_TYPE = 3'd0;

	// Gap windows in timer ticks.
	localparam logic [15:0] START_MIN = 16'd120;
	localparam logic [15:0] START_MAX = 16'd200;
	localparam logic [15:0] IDLE_MAX  = 16'd40;
	localparam logic [15:0] ZERO_MIN  = 16'd70;
	localparam logic [15:0] ZERO_MAX  = 16'd100;
	localparam logic [15:0] ONE_MIN   = 16'd110;
	localparam logic [15:0] ONE_MAX   = 16'd150;

	localparam logic SENSOR_TYPE_RESET = 1'b1;

endpackage

// ----- rtl/core/onewire_humidity_frame_decoder.sv -----
// Top level of the single-wire humidity and temperature frame decoder.
`timescale 1ns / 1ps

// The decoder takes one beat per clock cycle unless the input stalls: a start
// beat or a 16-bit edge capture time. Each beat is held in an input register
// and then handled by the gap classifier, which updates the receive state and,
// on a timing error or after the fortieth data bit, loads the result register.
// The sustained rate is one beat per cycle, set by the input and result
// registers, while the sink does not stall. The input stalls only while a beat
// waits in the input register behind a result that the sink is stalling.
// sensor_type is written over the APB port at byte address 0 and must be
// written only while no frame is in flight.
`include "assert_macros.svh"

module onewire_humidity_frame_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [15:0]                       capture_time,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [15:0]                       humidity,
	output logic signed [15:0]                temperature,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [owhfd_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// Configuration register
	logic sensor_type_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= owhfd_pkg::SENSOR_TYPE_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr == owhfd_pkg::ADDR_SENSOR_TYPE) begin
			sensor_type_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == owhfd_pkg::ADDR_SENSOR_TYPE) begin
			prdata[0] = sensor_type_q;
		end
	end

	// Input register
	logic        valid_s1;
	logic        op_s1;
	logic [15:0] cap_s1;
	logic        advance;
	logic        fire;
	logic        in_accept;

	assign advance   = !(out_valid && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= op;
			cap_s1 <= capture_time;
		end
	end

	// Receive state
	logic                          receiving_q;
	logic                          seen_start_q;
	logic [owhfd_pkg::CNT_W-1:0]   bit_count_q;
	logic [15:0]                   last_capture_q;
	logic [owhfd_pkg::FRAME_BITS-1:0] frame_q;

	logic                          receiving_d;
	logic                          seen_start_d;
	logic [owhfd_pkg::CNT_W-1:0]   bit_count_d;
	logic [15:0]                   last_capture_d;
	logic [owhfd_pkg::FRAME_BITS-1:0] frame_d;

	logic        emit;
	logic [1:0]  res_status;
	logic [15:0] res_hum;
	logic [15:0] res_temp;

	logic [15:0] gap;
	logic        in_start_win;
	logic        in_zero_win;
	logic        in_one_win;
	logic [owhfd_pkg::CNT_W-1:0] count_inc;
	logic [owhfd_pkg::FRAME_BITS-1:0] frame_shift;
	logic [7:0]  b0, b1, b2, b3, b4;
	logic [7:0]  sum8;
	logic [14:0] mag;
	logic [15:0] mag_ext;

	assign gap          = cap_s1 - last_capture_q;
	assign in_start_win = gap >= owhfd_pkg::START_MIN && gap <= owhfd_pkg::START_MAX;
	assign in_zero_win  = gap >= owhfd_pkg::ZERO_MIN && gap <= owhfd_pkg::ZERO_MAX;
	assign in_one_win   = gap >= owhfd_pkg::ONE_MIN && gap <= owhfd_pkg::ONE_MAX;
	assign count_inc    = bit_count_q + owhfd_pkg::CNT_W'(1);
	assign frame_shift  = {frame_q[owhfd_pkg::FRAME_BITS-2:0], in_one_win};

	// Bytes of the frame as it stands after this bit, first byte received on top.
	assign b0      = frame_shift[39:32];
	assign b1      = frame_shift[31:24];
	assign b2      = frame_shift[23:16];
	assign b3      = frame_shift[15:8];
	assign b4      = frame_shift[7:0];
	assign sum8    = b0 + b1 + b2 + b3;
	assign mag     = {b2[6:0], b3};
	assign mag_ext = {1'b0, mag};

	always_comb begin
		receiving_d    = receiving_q;
		seen_start_d   = seen_start_q;
		bit_count_d    = bit_count_q;
		last_capture_d = last_capture_q;
		frame_d        = frame_q;
		emit           = 1'b0;
		res_status     = owhfd_pkg::ST_OK;
		res_hum        = 16'd0;
		res_temp       = 16'd0;

		if (op_s1 == owhfd_pkg::OP_START) begin
			receiving_d    = 1'b1;
			seen_start_d   = 1'b0;
			bit_count_d    = '0;
			last_capture_d = 16'd0;
			frame_d        = '0;
		end else if (receiving_q) begin
			last_capture_d = cap_s1;
			if (!seen_start_q) begin
				if (in_start_win) begin
					seen_start_d = 1'b1;
				end else if (gap > owhfd_pkg::IDLE_MAX) begin
					emit       = 1'b1;
					res_status = owhfd_pkg::ST_TIMING;
				end
			end else if (in_zero_win || in_one_win) begin
				frame_d     = frame_shift;
				bit_count_d = count_inc;
				if (count_inc == owhfd_pkg::CNT_W'(owhfd_pkg::FRAME_BITS)) begin
					emit = 1'b1;
					if (sum8 != b4) begin
						res_status = owhfd_pkg::ST_CHECKSUM;
					end else if (!sensor_type_q) begin
						// Integer format: byte times ten, as 8x + 2x.
						res_hum  = {5'd0, b0, 3'd0} + {7'd0, b0, 1'b0};
						res_temp = {5'd0, b2, 3'd0} + {7'd0, b2, 1'b0};
					end else begin
						res_hum  = {b0, b1};
						// Sign-magnitude; a negative zero comes out as zero.
						res_temp = b2[7] ? (16'd0 - mag_ext) : mag_ext;
					end
				end
			end else begin
				emit       = 1'b1;
				res_status = owhfd_pkg::ST_TIMING;
			end
			if (emit) begin
				receiving_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q    <= 1'b0;
			seen_start_q   <= 1'b0;
			bit_count_q    <= '0;
			last_capture_q <= 16'd0;
			frame_q        <= '0;
		end else if (fire) begin
			receiving_q    <= receiving_d;
			seen_start_q   <= seen_start_d;
			bit_count_q    <= bit_count_d;
			last_capture_q <= last_capture_d;
			frame_q        <= frame_d;
		end
	end

	// Result register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] humidity_q;
	logic [15:0] temperature_q;
	logic        res_load;

	assign res_load = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q      <= res_status;
			humidity_q    <= res_hum;
			temperature_q <= res_temp;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign humidity    = humidity_q;
	assign temperature = signed'(temperature_q);

	// Checks
	`ASSERT_ALWAYS(a_err_zero_payload, clk, arst_n,
		!out_valid_q || status_q == owhfd_pkg::ST_OK ||
		(humidity_q == 16'd0 && temperature_q == 16'd0),
		"error result carries a nonzero payload")
	`ASSERT_NEXT(a_result_idles, clk, arst_n, res_load, !receiving_q,
		"receiver still active after a result")
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n,
		bit_count_q <= owhfd_pkg::CNT_W'(owhfd_pkg::FRAME_BITS),
		"bit count beyond frame length")
	`ASSERT_NEXT(a_stall_holds_beat, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(cap_s1) && $stable(op_s1),
		"buffered beat lost while result is stalled")

endmodule
